[rtl/nst_pkg.sv]
// Package with the types and constants of the named semaphore table.
`timescale 1ns / 1ps

package nst_pkg;

    // Default table size.
    localparam int NST_ENTRIES_DEF = 16;

    // Request commands.
    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_DESTROY  = 3'd1,
        CMD_GET      = 3'd2,
        CMD_RELEASE  = 3'd3,
        CMD_FREE_ALL = 3'd4
    } t_cmd;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OWNED   = 3'd1,
        ST_NOSUCH  = 3'd2,
        ST_DENIED  = 3'd3,
        ST_FULL    = 3'd4,
        ST_WAIT    = 3'd5,
        ST_BADCMD  = 3'd6
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    // Request beat.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] sem_id;
        logic [14:0] requester_pid;
        logic        may_wait;
    } t_req;

    // Result beat.
    typedef struct packed {
        t_status status;
        logic    wake_waiters;
    } t_rsp;

    // One stored table entry (the valid mark is kept apart in flip-flops).
    typedef struct packed {
        logic [31:0] id;
        logic [14:0] owner;
        logic        free;
    } t_entry;

endpackage

[rtl/nst_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module nst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/nst_ctrl.sv]
// Sequencer and shared compare unit that scan the semaphore table per request.
`timescale 1ns / 1ps

module nst_ctrl import nst_pkg::*; #(
    parameter int TABLE_ENTRIES = NST_ENTRIES_DEF,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_req          i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_take,
    output t_rsp          o_rsp,
    output logic          o_ram_we,
    output logic [IW-1:0] o_ram_waddr,
    output t_entry        o_ram_wdata,
    output logic [IW-1:0] o_ram_raddr,
    input  t_entry        i_ram_rdata
);

    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] COUNT    = CW'(TABLE_ENTRIES);

    t_state                   r_state, n_state;
    t_req                     r_req, n_req;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]            r_addr, n_addr;
    logic                     r_cvld, n_cvld;
    logic [IW-1:0]            r_cidx, n_cidx;
    logic                     r_hit, n_hit;
    logic [IW-1:0]            r_hit_idx, n_hit_idx;
    t_entry                   r_hit_ent, n_hit_ent;
    logic                     r_empty_found, n_empty_found;
    logic [IW-1:0]            r_empty_idx, n_empty_idx;
    logic                     r_any, n_any;
    t_rsp                     r_rsp, n_rsp;

    logic issue;
    logic cur_valid;
    logic id_match;
    logic pid_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_cvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cvld  <= n_cvld;
        end
        r_req         <= n_req;
        r_addr        <= n_addr;
        r_cidx        <= n_cidx;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_hit_ent     <= n_hit_ent;
        r_empty_found <= n_empty_found;
        r_empty_idx   <= n_empty_idx;
        r_any         <= n_any;
        r_rsp         <= n_rsp;
    end

    // The one compare unit: checks the entry read in the previous cycle.
    assign cur_valid = r_valid[r_cidx];
    assign id_match  = cur_valid && (i_ram_rdata.id == r_req.sem_id);
    assign pid_match = i_ram_rdata.owner == r_req.requester_pid;

    assign issue       = (r_state == S_SCAN) && (r_addr < COUNT);
    assign o_ram_raddr = r_addr[IW-1:0];
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_valid       = r_valid;
        n_addr        = r_addr;
        n_cvld        = 1'b0;
        n_cidx        = r_addr[IW-1:0];
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_hit_ent     = r_hit_ent;
        n_empty_found = r_empty_found;
        n_empty_idx   = r_empty_idx;
        n_any         = r_any;
        n_rsp         = r_rsp;
        o_ram_we      = 1'b0;
        o_ram_waddr   = r_cidx;
        o_ram_wdata   = i_ram_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req         = i_req;
                    n_addr        = '0;
                    n_hit         = 1'b0;
                    n_empty_found = 1'b0;
                    n_any         = 1'b0;
                    case (i_req.cmd)
                        CMD_CREATE, CMD_DESTROY, CMD_GET, CMD_RELEASE, CMD_FREE_ALL: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                    n_cvld = 1'b1;
                end
                if (r_cvld) begin
                    if (r_req.cmd == CMD_FREE_ALL) begin
                        // Free every entry the terminating process still holds.
                        if (cur_valid && !i_ram_rdata.free && pid_match) begin
                            o_ram_we         = 1'b1;
                            o_ram_waddr      = r_cidx;
                            o_ram_wdata      = i_ram_rdata;
                            o_ram_wdata.free = 1'b1;
                            n_any            = 1'b1;
                        end
                        if (r_cidx == LAST_IDX) begin
                            n_state = S_FINISH;
                            n_cvld  = 1'b0;
                        end
                    end else begin
                        if (!cur_valid && !r_empty_found) begin
                            n_empty_found = 1'b1;
                            n_empty_idx   = r_cidx;
                        end
                        // The first match ends the scan; ids are unique.
                        if (id_match) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_cidx;
                            n_hit_ent = i_ram_rdata;
                            n_state   = S_FINISH;
                            n_cvld    = 1'b0;
                        end else if (r_cidx == LAST_IDX) begin
                            n_state = S_FINISH;
                            n_cvld  = 1'b0;
                        end
                    end
                end
            end

            S_FINISH: begin
                n_state = S_DONE;
                n_rsp.status       = ST_OK;
                n_rsp.wake_waiters = 1'b0;
                o_ram_wdata.id     = r_req.sem_id;
                o_ram_wdata.owner  = r_req.requester_pid;
                o_ram_wdata.free   = 1'b0;
                case (r_req.cmd)
                    CMD_CREATE: begin
                        if (r_hit) begin
                            n_rsp.status = ST_DENIED;
                        end else if (!r_empty_found) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            o_ram_we             = 1'b1;
                            o_ram_waddr          = r_empty_idx;
                            n_valid[r_empty_idx] = 1'b1;
                        end
                    end
                    CMD_DESTROY, CMD_RELEASE: begin
                        if (!r_hit) begin
                            n_rsp.status = ST_NOSUCH;
                        end else if (!r_hit_ent.free &&
                                     (r_hit_ent.owner != r_req.requester_pid)) begin
                            n_rsp.status = ST_DENIED;
                        end else begin
                            n_rsp.wake_waiters = 1'b1;
                            if (r_req.cmd == CMD_RELEASE) begin
                                o_ram_we         = 1'b1;
                                o_ram_waddr      = r_hit_idx;
                                o_ram_wdata      = r_hit_ent;
                                o_ram_wdata.free = 1'b1;
                            end else begin
                                n_valid[r_hit_idx] = 1'b0;
                            end
                        end
                    end
                    CMD_GET: begin
                        if (!r_hit) begin
                            n_rsp.status = ST_NOSUCH;
                        end else if (r_hit_ent.free) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_hit_idx;
                        end else if (r_hit_ent.owner == r_req.requester_pid) begin
                            n_rsp.status = ST_OWNED;
                        end else begin
                            n_rsp.status = r_req.may_wait ? ST_WAIT : ST_DENIED;
                        end
                    end
                    CMD_FREE_ALL: begin
                        n_rsp.wake_waiters = r_any;
                    end
                    default: begin
                        n_rsp.status = ST_BADCMD;
                    end
                endcase
            end

            S_DONE: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/named_semaphore_table.sv]
// Top level of the named semaphore table: sequencer, entry memory and output register.
`timescale 1ns / 1ps

// Named semaphore table.
// Requests arrive as beats on the input channel (i_in_valid, o_in_ready,
// i_in_data) and each one gives exactly one result beat on the output
// channel (o_out_valid, i_out_ready, o_out_data) with a status and a
// wake-waiters flag. Sleeping and timeouts stay with the requester.
// The block works on one request at a time. It reads one table entry per
// cycle from the entry memory through a single compare unit; a create,
// destroy, get or release whose id is found stops the scan at the
// matching entry, and an invalid command skips the scan. The next
// request is taken in the cycle after the previous result has moved
// into the output register.
// A result that the receiver stalls waits in the output register while
// the next request is already accepted and scanned; that request then
// holds its finished result until the output register frees up.
// Reset empties the table at once by clearing the per-entry valid marks;
// the id, owner and free fields need no clearing pass.
module named_semaphore_table import nst_pkg::*; #(
    parameter int TABLE_ENTRIES = NST_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [IW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic rsp_valid;
    logic rsp_take;
    t_rsp rsp;

    logic r_out_valid;
    t_rsp r_out_data;

    // The sequencer and its compare unit.
    nst_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_in_valid),
        .o_req_ready(o_in_ready),
        .i_req      (i_in_data),
        .o_rsp_valid(rsp_valid),
        .i_rsp_take (rsp_take),
        .o_rsp      (rsp),
        .o_ram_we   (ram_we),
        .o_ram_waddr(ram_waddr),
        .o_ram_wdata(ram_wdata),
        .o_ram_raddr(ram_raddr),
        .i_ram_rdata(ram_rdata)
    );

    // Id, owner and free mark of every entry.
    nst_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // The output register takes a finished result whenever it is empty or
    // its current beat leaves in this cycle.
    assign rsp_take = rsp_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (rsp_take) begin
            r_out_data <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
